/* hw/rtl/lbct_pkg.sv */
// Shared types and constants for the LRU block cache tag store.
// Used by lbct_front, lbct_queue, lbct_back and lru_block_cache_tags.
package lbct_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LVLS    = $clog2(ENTRIES);
    localparam int BLK_W   = 32;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 3;
    localparam int FSEC_W  = 35;
    localparam int SCNT_W  = 4;
    localparam int LBS_W   = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int        PADDR_W = 3;
    localparam logic [2:0] REG_LBS_ADDR = 3'd0;
    localparam logic [1:0] LBS_MAX = 2'd2;

    typedef enum logic [0:0] {
        CMD_LOOKUP = 1'b0,
        CMD_INVAL  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [0:0]       command;
        logic [BLK_W-1:0] block_number;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              fetch_needed;
        logic [FSEC_W-1:0] fetch_sector;
        logic [SCNT_W-1:0] sector_count;
    } t_rsp;

    typedef struct packed {
        t_cmd             kind;
        logic [BLK_W-1:0] blk;
    } t_op;

    typedef struct packed {
        logic vld;
        t_op  op;
    } t_push;

    typedef struct packed {
        logic [Q_CW-1:0] count;
    } t_q_stat;

endpackage

/* hw/rtl/lbct_front.sv */
// Front end: takes commands, decodes them and stages them for the queue.
// Depends on lbct_pkg.
module lbct_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  lbct_pkg::t_req  i_req,
    input  lbct_pkg::t_q_stat i_stat,
    output logic            o_busy,
    output lbct_pkg::t_push o_push
);
    import lbct_pkg::*;

    logic r_vld;
    logic n_vld;
    t_op  r_op;
    t_op  n_op;
    logic take;

    // hold off while the queue could not absorb the staged op plus a new one
    assign o_busy = ((Q_CW+1)'(i_stat.count) + (Q_CW+1)'(r_vld)) >= (Q_CW+1)'(Q_DEPTH);
    assign take   = i_start && !o_busy;

    always_comb begin
        n_vld   = take;
        n_op    = r_op;
        if (take) begin
            n_op.kind = (i_req.command == CMD_INVAL) ? CMD_INVAL : CMD_LOOKUP;
            n_op.blk  = i_req.block_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_op <= n_op;
    end

    assign o_push.vld = r_vld;
    assign o_push.op  = r_op;

endmodule

/* hw/rtl/lbct_queue.sv */
// Short FIFO between the front end and the tag engine.
// Depends on lbct_pkg.
module lbct_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbct_pkg::t_push   i_push,
    input  logic              i_pop,
    output lbct_pkg::t_op     o_head,
    output logic              o_vld,
    output lbct_pkg::t_q_stat o_stat
);
    import lbct_pkg::*;

    t_op             r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;
    logic [Q_AW-1:0] n_wp;
    logic [Q_AW-1:0] n_rp;
    logic [Q_CW-1:0] n_cnt;
    logic            do_pop;
    logic            do_push;

    assign o_vld   = (r_cnt != '0);
    assign do_pop  = i_pop && o_vld;
    assign do_push = i_push.vld;
    assign o_head  = r_mem[r_rp];
    assign o_stat.count = r_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == Q_AW'(Q_DEPTH-1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == Q_AW'(Q_DEPTH-1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wp] <= i_push.op;
        end
    end

endmodule

/* hw/rtl/lbct_back.sv */
// Tag engine: tag/valid/stamp store, hit search, LRU victim choice, result register.
// Depends on lbct_pkg.
module lbct_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  lbct_pkg::t_op             i_op,
    input  logic [lbct_pkg::LBS_W-1:0] i_lbs,
    output logic                      o_pop,
    output logic                      o_done,
    output lbct_pkg::t_rsp            o_rsp
);
    import lbct_pkg::*;

    logic [BLK_W-1:0]   r_tag   [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [STAMP_W-1:0] r_stamp [ENTRIES];
    logic [STAMP_W-1:0] r_clk;
    logic               r_done;
    t_rsp               r_rsp;

    logic [ENTRIES-1:0] hit_vec;
    logic               hit_any;
    logic [IDX_W-1:0]   hit_idx;
    logic               inv_any;
    logic [IDX_W-1:0]   inv_idx;
    logic [STAMP_W-1:0] lv_st  [LVLS+1][ENTRIES];
    logic [IDX_W-1:0]   lv_idx [LVLS+1][ENTRIES];
    logic [IDX_W-1:0]   victim;
    logic [IDX_W-1:0]   sel_idx;
    logic [STAMP_W-1:0] n_clk;
    logic [1:0]         lg;
    logic [SCNT_W-1:0]  spb;
    t_rsp               n_rsp;
    logic               is_lookup;

    assign o_pop     = i_vld;
    assign is_lookup = i_vld && (i_op.kind == CMD_LOOKUP);

    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = ENTRIES-1; i >= 0; i--) begin
            hit_vec[i] = r_valid[i] && (r_tag[i] == i_op.blk);
            if (hit_vec[i]) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // first free slot, slot 0 excluded
    always_comb begin
        inv_any = 1'b0;
        inv_idx = '0;
        for (int i = ENTRIES-1; i >= 1; i--) begin
            if (!r_valid[i]) begin
                inv_any = 1'b1;
                inv_idx = IDX_W'(i);
            end
        end
    end

    // oldest stamp, lower index kept on ties
    always_comb begin
        int cnt;
        for (int j = 0; j < ENTRIES; j++) begin
            lv_st[0][j]  = r_stamp[j];
            lv_idx[0][j] = IDX_W'(j);
        end
        for (int l = 0; l < LVLS; l++) begin
            cnt = (ENTRIES + (1 << l) - 1) >> l;
            for (int j = 0; j < ENTRIES; j++) begin
                lv_st[l+1][j]  = '0;
                lv_idx[l+1][j] = '0;
            end
            for (int j = 0; j < (ENTRIES + 1) / 2; j++) begin
                if (2*j + 1 < cnt) begin
                    if (lv_st[l][2*j+1] < lv_st[l][2*j]) begin
                        lv_st[l+1][j]  = lv_st[l][2*j+1];
                        lv_idx[l+1][j] = lv_idx[l][2*j+1];
                    end else begin
                        lv_st[l+1][j]  = lv_st[l][2*j];
                        lv_idx[l+1][j] = lv_idx[l][2*j];
                    end
                end else if (2*j < cnt) begin
                    lv_st[l+1][j]  = lv_st[l][2*j];
                    lv_idx[l+1][j] = lv_idx[l][2*j];
                end
            end
        end
    end

    assign victim  = inv_any ? inv_idx : lv_idx[LVLS][0];
    assign sel_idx = hit_any ? hit_idx : victim;
    assign n_clk   = r_clk + 1'b1;
    assign lg      = (i_lbs > LBS_MAX) ? 2'd0 : i_lbs;
    assign spb     = SCNT_W'(2) << lg;

    always_comb begin
        n_rsp = '0;
        if (is_lookup) begin
            n_rsp.slot = SLOT_W'(sel_idx);
            if (hit_any) begin
                n_rsp.hit = 1'b1;
            end else begin
                n_rsp.fetch_needed = 1'b1;
                n_rsp.fetch_sector = FSEC_W'(i_op.blk) << (lg + 2'd1);
                n_rsp.sector_count = spb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_clk   <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_stamp[i] <= '0;
            end
        end else begin
            r_done <= i_vld;
            if (i_vld && i_op.kind == CMD_INVAL) begin
                r_valid <= '0;
            end else if (is_lookup) begin
                r_clk            <= n_clk;
                r_stamp[sel_idx] <= n_clk;
                if (!hit_any) begin
                    r_valid[sel_idx] <= 1'b1;
                end
            end
        end
        if (is_lookup && !hit_any) begin
            r_tag[victim] <= i_op.blk;
        end
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

/* hw/rtl/lru_block_cache_tags.sv */
// Path from the start transfer to the result transfer (o_done): front staging register, queue, result register.
// The tag engine completes each lookup (tag compare, min tree, stamp update) while its op is at the queue head.
// busy is high while queue count plus the staged front op reach two: back to back, busy goes
// high for one cycle after every second transfer.
// Reset (i_rst_n low, synchronous): valid bits, stamps, use clock and log_block_size cleared.
// Top level: APB register, front end, queue and tag engine. Depends on lbct_pkg and submodules.
module lru_block_cache_tags (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  lbct_pkg::t_req               i_req,
    output logic                         o_done,
    output lbct_pkg::t_rsp               o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lbct_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import lbct_pkg::*;

    logic [LBS_W-1:0] r_lbs;
    t_push            push;
    t_q_stat          q_stat;
    t_op              head;
    logic             head_vld;
    logic             pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lbs <= '0;
        end else if (psel && penable && pwrite && paddr == REG_LBS_ADDR) begin
            r_lbs <= pwdata[LBS_W-1:0];
        end
    end

    assign prdata = (paddr == REG_LBS_ADDR) ? {{(32-LBS_W){1'b0}}, r_lbs} : 32'd0;

    lbct_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .i_stat  (q_stat),
        .o_busy  (busy),
        .o_push  (push)
    );

    lbct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_vld   (head_vld),
        .o_stat  (q_stat)
    );

    lbct_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (head_vld),
        .i_op    (head),
        .i_lbs   (r_lbs),
        .o_pop   (pop),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    a_hit_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_rsp.hit && o_rsp.fetch_needed))
        else $error("hit and fetch both set");

    a_fetch_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.fetch_needed) |->
            (o_rsp.sector_count == 4'd2 || o_rsp.sector_count == 4'd4 ||
             o_rsp.sector_count == 4'd8))
        else $error("bad sector count on miss");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.hit) |-> (o_rsp.fetch_sector == '0 && o_rsp.sector_count == '0))
        else $error("fetch fields set on hit");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= Q_CW'(Q_DEPTH))
        else $error("queue overflow");

endmodule
